// ===== hw/rtl/sliding_window_median_assert.svh =====
// assertion macros for the sliding window median block
// expects clk and rst_n in the scope where a macro is used
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

`ifndef SYNTH
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWM_ASSERT(lbl, prop, msg)
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/swm_pkg.sv =====
// shared types and constants for the sliding window median block
// no dependencies
package swm_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int OUT_W        = 33;
    localparam int CFG_W        = 7;
    localparam int RESET_WINDOW = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0]    median_t;

    // movement of a cell's value during one update
    typedef struct packed {
        logic kept;
        logic up;
        logic down;
    } swm_flags_t;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// one cell of the sorted window: holds a value and its age
// moves its value up, down or keeps it, and takes the new sample into the gap
// depends on swm_pkg
module swm_cell
    import swm_pkg::*;
#(
    parameter int AGE_W = 6
)
(
    input  logic             clk,
    input  logic             load,
    input  sample_t          sample,
    input  logic             held,
    input  logic             full,
    input  logic [AGE_W-1:0] oldest_age,
    input  logic             rm_before,
    input  swm_flags_t       left_flags,
    input  sample_t          left_val,
    input  logic [AGE_W-1:0] left_age,
    input  swm_flags_t       right_flags,
    input  sample_t          right_val,
    input  logic [AGE_W-1:0] right_age,
    output logic             rm,
    output swm_flags_t       flags,
    output sample_t          val,
    output logic [AGE_W-1:0] age
);

    sample_t          val_reg;
    sample_t          val_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             le;

    assign le = (val_reg <= sample);
    assign rm = held && full && (age_reg == oldest_age);

    always_comb
    begin
        flags.kept = held && !rm;
        flags.up   = held && !rm && !le && !rm_before;
        flags.down = held && !rm && le && rm_before;
    end

    always_comb
    begin
        if (left_flags.kept && left_flags.up)
        begin
            val_next = left_val;
            age_next = left_age + AGE_W'(1);
        end
        else if (right_flags.kept && right_flags.down)
        begin
            val_next = right_val;
            age_next = right_age + AGE_W'(1);
        end
        else if (flags.kept && !flags.up && !flags.down)
        begin
            val_next = val_reg;
            age_next = age_reg + AGE_W'(1);
        end
        else
        begin
            val_next = sample;
            age_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

// ===== hw/rtl/sliding_window_median.sv =====
// sliding window median: twice the median of the last window_size samples
// pipeline: the cell row takes the accepted item, then the median register
// throughput: one item per cycle while no result waits on a stalled output
// the whole row updates at once; the adder reads it when the output frees
// reset: window empty, window size 3 (capped at MAX_WINDOW), no result pending
// depends on swm_pkg, swm_cell and sliding_window_median_assert.svh
`include "sliding_window_median_assert.svh"

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sample_t          sample,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output median_t          median_doubled,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int WW     = $clog2(MAX_WINDOW + 1);
    localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RST_W  = (RESET_WINDOW < MAX_WINDOW) ? RESET_WINDOW : MAX_WINDOW;
    localparam int RST_HI = RST_W / 2;
    localparam int RST_LO = (RST_W - 1) / 2;

    logic [WW-1:0] win_reg;
    logic [AW-1:0] hi_reg;
    logic [AW-1:0] lo_reg;
    logic [WW-1:0] fill_reg;
    logic [WW-1:0] fill_next;
    logic          pend_reg;
    logic          pend_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    median_t       median_reg;
    logic [WW-1:0] win_wr;

    logic [WW-1:0] base;
    logic          full;
    logic          res_now;
    logic          in_fire;
    logic          can_load;
    logic [AW-1:0] oldest_age;

    logic [MAX_WINDOW-1:0] rm_vec;
    logic [MAX_WINDOW-1:0] rmb_vec;
    logic [MAX_WINDOW-1:0] held_vec;
    swm_flags_t            flags_arr [MAX_WINDOW];
    sample_t               val_arr   [MAX_WINDOW];
    logic [AW-1:0]         age_arr   [MAX_WINDOW];

    // window size written through the config port, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (cfg_wdata == '0)
            win_wr = WW'(1);
        else if (int'(cfg_wdata) > MAX_WINDOW)
            win_wr = WW'(MAX_WINDOW);
        else
            win_wr = WW'(cfg_wdata);
    end

    assign base       = restart ? '0 : fill_reg;
    assign full       = (base == win_reg);
    assign fill_next  = full ? win_reg : base + WW'(1);
    assign res_now    = (fill_next == win_reg);
    assign oldest_age = AW'(win_reg - WW'(1));

    assign can_load = !out_valid_reg || out_ready;
    assign in_ready = !pend_reg || can_load;
    assign in_fire  = in_valid && in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            swm_flags_t    lf;
            sample_t       lv;
            logic [AW-1:0] la;
            swm_flags_t    rf;
            sample_t       rv;
            logic [AW-1:0] ra;

            assign held_vec[gi] = (base > WW'(gi));

            if (gi == 0)
            begin : g_first
                assign rmb_vec[gi] = 1'b0;
                assign lf = '0;
                assign lv = '0;
                assign la = '0;
            end
            else
            begin : g_inner
                assign rmb_vec[gi] = |rm_vec[gi-1:0];
                assign lf = flags_arr[gi-1];
                assign lv = val_arr[gi-1];
                assign la = age_arr[gi-1];
            end

            if (gi == MAX_WINDOW - 1)
            begin : g_last
                assign rf = '0;
                assign rv = '0;
                assign ra = '0;
            end
            else
            begin : g_upper
                assign rf = flags_arr[gi+1];
                assign rv = val_arr[gi+1];
                assign ra = age_arr[gi+1];
            end

            swm_cell #(
                .AGE_W (AW)
            ) u_cell (
                .clk         (clk),
                .load        (in_fire),
                .sample      (sample),
                .held        (held_vec[gi]),
                .full        (full),
                .oldest_age  (oldest_age),
                .rm_before   (rmb_vec[gi]),
                .left_flags  (lf),
                .left_val    (lv),
                .left_age    (la),
                .right_flags (rf),
                .right_val   (rv),
                .right_age   (ra),
                .rm          (rm_vec[gi]),
                .flags       (flags_arr[gi]),
                .val         (val_arr[gi]),
                .age         (age_arr[gi])
            );
        end
    endgenerate

    always_comb
    begin
        if (in_fire)
            pend_next = res_now;
        else if (can_load)
            pend_next = 1'b0;
        else
            pend_next = pend_reg;
    end

    assign out_valid_next = can_load ? pend_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WW'(RST_W);
            hi_reg        <= AW'(RST_HI);
            lo_reg        <= AW'(RST_LO);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_reg  <= win_wr;
                hi_reg   <= AW'(win_wr >> 1);
                lo_reg   <= AW'((win_wr - WW'(1)) >> 1);
                fill_reg <= '0;
            end
            else if (in_fire)
            begin
                fill_reg <= fill_next;
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sum of the two middle cells, read from the row after its update
    always_ff @(posedge clk)
    begin
        if (can_load && pend_reg)
            median_reg <= median_t'(val_arr[hi_reg]) + median_t'(val_arr[lo_reg]);
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;

    `SWM_ASSERT(a_fill_bound, fill_reg <= win_reg, "fill count above window size")
    `SWM_ASSERT(a_one_removal, $onehot0(rm_vec), "more than one cell leaving the window")
    `SWM_ASSERT_NEXT(a_result_pending, in_fire && res_now, pend_reg, "result lost after item")
    `SWM_ASSERT(a_stall_blocks, (pend_reg && !can_load) |-> !in_ready, "item taken while stalled")
    `SWM_ASSERT_NEXT(a_pend_to_out, pend_reg && can_load, out_valid, "pending result not shown")

endmodule
